@@ rtl/plx_pkg.sv @@
// shared types, constants and helpers for the pascal subset lexer
// used by plx_core, plx_outq and pascal_subset_lexer
package plx_pkg;

  localparam int unsigned LINE_BITS_DEF   = 16;
  localparam int unsigned COLUMN_BITS_DEF = 16;
  localparam int unsigned NKW             = 11;
  localparam int unsigned KW_SLOTS        = 8;
  localparam int unsigned OUTQ_DEPTH      = 4;

  // lexer modes
  typedef enum logic [2:0] {
    MODE_BEGIN,
    MODE_IDENT,
    MODE_INTEGER,
    MODE_STRING,
    MODE_COMMENT,
    MODE_LARGER,
    MODE_SMALLER,
    MODE_ASSIGN
  } mode_e;

  // result kinds
  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_IDENT    = 5'd1;
  localparam logic [4:0] KIND_INTEGER  = 5'd2;
  localparam logic [4:0] KIND_STRING   = 5'd3;
  localparam logic [4:0] KIND_KW_FIRST = 5'd4;
  localparam logic [4:0] KIND_RPAREN   = 5'd15;
  localparam logic [4:0] KIND_LPAREN   = 5'd16;
  localparam logic [4:0] KIND_RBRACK   = 5'd17;
  localparam logic [4:0] KIND_LBRACK   = 5'd18;
  localparam logic [4:0] KIND_EQUAL    = 5'd19;
  localparam logic [4:0] KIND_PLUS     = 5'd20;
  localparam logic [4:0] KIND_MINUS    = 5'd21;
  localparam logic [4:0] KIND_STAR     = 5'd22;
  localparam logic [4:0] KIND_SLASH    = 5'd23;
  localparam logic [4:0] KIND_LARGER   = 5'd24;
  localparam logic [4:0] KIND_SMALLER  = 5'd25;
  localparam logic [4:0] KIND_COMMA    = 5'd26;
  localparam logic [4:0] KIND_SEMI     = 5'd27;
  localparam logic [4:0] KIND_COLON    = 5'd28;
  localparam logic [4:0] KIND_ASSIGN   = 5'd29;
  localparam logic [4:0] KIND_BAD      = 5'd30;
  localparam logic [4:0] KIND_OPEN_STR = 5'd31;

  // special characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // keyword spellings, zero padded
  localparam logic [7:0] KW_TEXT [NKW][KW_SLOTS] = '{
    '{"B", "E", "G", "I", "N", 8'h00, 8'h00, 8'h00},
    '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"T", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"R", "E", "P", "E", "A", "T", 8'h00, 8'h00},
    '{"U", "N", "T", "I", "L", 8'h00, 8'h00, 8'h00},
    '{"D", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"V", "A", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "N", "T", "E", "G", "E", "R", 8'h00},
    '{"C", "O", "N", "S", "T", 8'h00, 8'h00, 8'h00},
    '{"D", "O", "W", "N", "T", "O", 8'h00, 8'h00}
  };
  localparam logic [7:0] KW_LEN [NKW] = '{
    8'd5, 8'd3, 8'd3, 8'd2, 8'd6, 8'd5, 8'd2, 8'd3, 8'd7, 8'd5, 8'd6
  };

  typedef struct packed {
    logic        is_text;
    logic [7:0]  text_char;
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  text_length;
    logic        last;
  } res_t;

  // results of one lexer step toward the output queue
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic [15:0] clamp16(input logic [31:0] v);
    clamp16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0" && c <= "9");
  endfunction

  // single character punctuation, bad character otherwise
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    case (c)
      ")":     punct_kind = KIND_RPAREN;
      "(":     punct_kind = KIND_LPAREN;
      "]":     punct_kind = KIND_RBRACK;
      "[":     punct_kind = KIND_LBRACK;
      "=":     punct_kind = KIND_EQUAL;
      "+":     punct_kind = KIND_PLUS;
      "-":     punct_kind = KIND_MINUS;
      "*":     punct_kind = KIND_STAR;
      "/":     punct_kind = KIND_SLASH;
      ",":     punct_kind = KIND_COMMA;
      ";":     punct_kind = KIND_SEMI;
      default: punct_kind = KIND_BAD;
    endcase
  endfunction

endpackage

@@ rtl/plx_if.sv @@
// valid/ready channel interfaces for source characters and lexer results
// standalone, no package needed
interface plx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface plx_tok_if;
  logic        valid;
  logic        ready;
  logic        is_text;
  logic [7:0]  text_char;
  logic [4:0]  kind;
  logic [15:0] line;
  logic [15:0] column;
  logic [7:0]  text_length;
  logic        last;

  modport source (output valid, output is_text, output text_char, output kind,
                  output line, output column, output text_length, output last,
                  input ready);
  modport sink (input valid, input is_text, input text_char, input kind,
                input line, input column, input text_length, input last,
                output ready);
endinterface

@@ rtl/pascal_subset_lexer.sv @@
// pascal subset lexer top level: character input register and step logic,
// then a four-entry result queue; depends on plx_pkg, plx_if, plx_core, plx_outq
// a character is held in the input register until the queue has room, then its
//   results are written into the queue, which hands them out in order
// throughput: one character per cycle while at most two results wait; input
//   stalls once three results wait, as two-result characters can fill the queue
// reset: asynchronous, active low; clears mode, keyword mask, counters, queue
module pascal_subset_lexer #(
  parameter int unsigned LINE_BITS   = plx_pkg::LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = plx_pkg::COLUMN_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  plx_char_if.sink   char_i,
  plx_tok_if.source  tok_o
);
  import plx_pkg::*;

  push_t push;
  logic  room;
  res_t  res;

  plx_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .in_char_i  (char_i.character),
    .room_i     (room),
    .push_o     (push)
  );

  plx_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (tok_o.valid),
    .out_ready_i (tok_o.ready),
    .out_res_o   (res)
  );

  assign tok_o.is_text     = res.is_text;
  assign tok_o.text_char   = res.text_char;
  assign tok_o.kind        = res.kind;
  assign tok_o.line        = res.line;
  assign tok_o.column      = res.column;
  assign tok_o.text_length = res.text_length;
  assign tok_o.last        = res.last;

endmodule

@@ rtl/plx_core.sv @@
// lexer step: input character register, lexer state and the per-character
// logic that yields up to two results; depends on plx_pkg
module plx_core #(
  parameter int unsigned LINE_BITS   = plx_pkg::LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = plx_pkg::COLUMN_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_char_i,
  input  logic          room_i,
  output plx_pkg::push_t push_o
);
  import plx_pkg::*;

  logic                   s_valid_q;
  logic [7:0]             s_char_q;
  mode_e                  mode_q, mode_d;
  logic [NKW-1:0]         kw_q, kw_d;
  logic [7:0]             len_q, len_d;
  logic [LINE_BITS-1:0]   tline_q, tline_d, cline_q, cline_d, adv_line;
  logic [COLUMN_BITS-1:0] tcol_q, tcol_d, ccol_q, ccol_d, adv_col;
  logic                   fire;

  assign fire       = s_valid_q && room_i;
  assign in_ready_o = !s_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s_char_q <= in_char_i;
    end
  end

  function automatic res_t make_res(input logic is_text, input logic [7:0] ch,
                                    input logic [4:0] kind, input logic [31:0] ln,
                                    input logic [31:0] col, input logic [7:0] len);
    res_t r;
    r.is_text     = is_text;
    r.text_char   = ch;
    r.kind        = kind;
    r.line        = clamp16(ln);
    r.column      = clamp16(col);
    r.text_length = len;
    r.last        = 1'b0;
    return r;
  endfunction

  // position after consuming the current character
  always_comb begin
    adv_line = cline_q;
    adv_col  = ccol_q;
    if (s_char_q == CH_LF) begin
      if (cline_q != '1) adv_line = cline_q + 1'b1;
      adv_col = '0;
    end else if (ccol_q != '1) begin
      adv_col = ccol_q + 1'b1;
    end
  end

  always_comb begin
    logic [7:0]     c;
    logic           begin_run;
    logic           b_emit;
    logic           do_restart;
    logic [1:0]     cnt;
    res_t           r0, r1, rb;
    logic [4:0]     id_kind;
    logic [4:0]     pk;
    logic [7:0]     len_inc;
    logic [NKW-1:0] kw_adv;
    logic [NKW-1:0] kw_first;

    c          = s_char_q;
    begin_run  = 1'b0;
    b_emit     = 1'b0;
    do_restart = 1'b0;
    cnt        = 2'd0;
    r0         = '0;
    r1         = '0;
    rb         = '0;
    mode_d     = mode_q;
    kw_d       = kw_q;
    len_d      = len_q;
    tline_d    = tline_q;
    tcol_d     = tcol_q;
    cline_d    = cline_q;
    ccol_d     = ccol_q;

    len_inc = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
    id_kind = KIND_IDENT;
    for (int k = 0; k < NKW; k++) begin
      kw_adv[k]   = kw_q[k] && !((len_q >= KW_LEN[k]) || (KW_TEXT[k][len_q[2:0]] != c));
      kw_first[k] = (KW_TEXT[k][0] == c);
      if (kw_q[k] && (len_q == KW_LEN[k])) id_kind = 5'(KIND_KW_FIRST + 5'(k));
    end
    pk = punct_kind(c);

    unique case (mode_q)
      MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
          kw_d  = kw_adv;
          len_d = len_inc;
          r0 = make_res(1'b1, c, KIND_IDENT, 32'(tline_q), 32'(tcol_q), len_inc);
          cnt = 2'd1;
          cline_d = adv_line;
          ccol_d  = adv_col;
        end else begin
          r0 = make_res(1'b0, CH_NUL, id_kind, 32'(tline_q), 32'(tcol_q), len_q);
          cnt = 2'd1;
          begin_run = 1'b1;
        end
      end
      MODE_INTEGER: begin
        if (is_digit(c)) begin
          len_d = len_inc;
          r0 = make_res(1'b1, c, KIND_INTEGER, 32'(tline_q), 32'(tcol_q), len_inc);
          cnt = 2'd1;
          cline_d = adv_line;
          ccol_d  = adv_col;
        end else begin
          r0 = make_res(1'b0, CH_NUL, KIND_INTEGER, 32'(tline_q), 32'(tcol_q), len_q);
          cnt = 2'd1;
          begin_run = 1'b1;
        end
      end
      MODE_STRING: begin
        if (c == CH_NUL) begin
          r0 = make_res(1'b0, CH_NUL, KIND_OPEN_STR, 32'(tline_q), 32'(tcol_q), len_q);
          cnt = 2'd1;
          do_restart = 1'b1;
        end else if (c == CH_QUOTE) begin
          r0 = make_res(1'b0, CH_NUL, KIND_STRING, 32'(tline_q), 32'(tcol_q), len_q);
          cnt = 2'd1;
          mode_d  = MODE_BEGIN;
          cline_d = adv_line;
          ccol_d  = adv_col;
        end else begin
          len_d = len_inc;
          r0 = make_res(1'b1, c, KIND_STRING, 32'(tline_q), 32'(tcol_q), len_inc);
          cnt = 2'd1;
          cline_d = adv_line;
          ccol_d  = adv_col;
        end
      end
      MODE_COMMENT: begin
        if (c != CH_NUL && c != CH_LF) begin
          cline_d = adv_line;
          ccol_d  = adv_col;
        end else begin
          begin_run = 1'b1;
        end
      end
      MODE_LARGER: begin
        r0 = make_res(1'b0, CH_NUL, KIND_LARGER, 32'(tline_q), 32'(tcol_q), 8'd0);
        cnt = 2'd1;
        begin_run = 1'b1;
      end
      MODE_SMALLER: begin
        r0 = make_res(1'b0, CH_NUL, KIND_SMALLER, 32'(tline_q), 32'(tcol_q), 8'd0);
        cnt = 2'd1;
        begin_run = 1'b1;
      end
      MODE_ASSIGN: begin
        if (c == CH_EQUAL) begin
          r0 = make_res(1'b0, CH_NUL, KIND_ASSIGN, 32'(tline_q), 32'(tcol_q), 8'd0);
          cnt = 2'd1;
          mode_d  = MODE_BEGIN;
          cline_d = adv_line;
          ccol_d  = adv_col;
        end else begin
          r0 = make_res(1'b0, CH_NUL, KIND_COLON, 32'(tline_q), 32'(tcol_q), 8'd0);
          cnt = 2'd1;
          begin_run = 1'b1;
        end
      end
      default: begin
        begin_run = 1'b1;
      end
    endcase

    // character handled from the begin state, seeing the unadvanced counters
    if (begin_run) begin
      mode_d = MODE_BEGIN;
      if (c == CH_NUL) begin
        rb = make_res(1'b0, CH_NUL, KIND_END, 32'(cline_q), 32'(ccol_q), 8'd0);
        b_emit     = 1'b1;
        do_restart = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        cline_d = adv_line;
        ccol_d  = adv_col;
      end else if (c == CH_PERCENT) begin
        mode_d  = MODE_COMMENT;
        cline_d = adv_line;
        ccol_d  = adv_col;
      end else if (is_alpha(c) || is_digit(c)) begin
        tline_d = cline_q;
        tcol_d  = ccol_q;
        len_d   = 8'd1;
        if (is_alpha(c)) begin
          kw_d   = kw_first;
          mode_d = MODE_IDENT;
          rb = make_res(1'b1, c, KIND_IDENT, 32'(cline_q), 32'(ccol_q), 8'd1);
        end else begin
          mode_d = MODE_INTEGER;
          rb = make_res(1'b1, c, KIND_INTEGER, 32'(cline_q), 32'(ccol_q), 8'd1);
        end
        b_emit  = 1'b1;
        cline_d = adv_line;
        ccol_d  = adv_col;
      end else if (c == CH_QUOTE || c == CH_GREATER || c == CH_LESS || c == CH_COLON) begin
        tline_d = cline_q;
        tcol_d  = ccol_q;
        len_d   = 8'd0;
        if (c == CH_QUOTE)        mode_d = MODE_STRING;
        else if (c == CH_GREATER) mode_d = MODE_LARGER;
        else if (c == CH_LESS)    mode_d = MODE_SMALLER;
        else                      mode_d = MODE_ASSIGN;
        cline_d = adv_line;
        ccol_d  = adv_col;
      end else begin
        rb = make_res(1'b0, CH_NUL, pk, 32'(cline_q), 32'(ccol_q), 8'd0);
        b_emit = 1'b1;
        if (pk == KIND_BAD) begin
          do_restart = 1'b1;
        end else begin
          cline_d = adv_line;
          ccol_d  = adv_col;
        end
      end
    end

    if (b_emit) begin
      if (cnt == 2'd0) r0 = rb;
      else             r1 = rb;
      cnt = cnt + 2'd1;
    end

    if (cnt == 2'd2)      r1.last = 1'b1;
    else if (cnt == 2'd1) r0.last = 1'b1;

    // end token or error: back to the reset state
    if (do_restart) begin
      mode_d  = MODE_BEGIN;
      kw_d    = '0;
      len_d   = '0;
      tline_d = '0;
      tcol_d  = '0;
      cline_d = '0;
      ccol_d  = '0;
    end

    push_o.count = fire ? cnt : 2'd0;
    push_o.res0  = r0;
    push_o.res1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BEGIN;
      kw_q    <= '0;
      len_q   <= '0;
      tline_q <= '0;
      tcol_q  <= '0;
      cline_q <= '0;
      ccol_q  <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      len_q   <= len_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      cline_q <= cline_d;
      ccol_q  <= ccol_d;
    end
  end

endmodule

@@ rtl/plx_outq.sv @@
// result queue: takes up to two results per beat, hands out one per beat
// depends on plx_pkg
module plx_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plx_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output plx_pkg::res_t  out_res_o
);
  import plx_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  res_t                mem_q [OUTQ_DEPTH];
  logic [PTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                pop;

  // room for a two-result beat, regardless of a pop in the same cycle
  assign room_o      = cnt_q <= CNT_BITS'(OUTQ_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_next     = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + PTR_BITS'(push_i.count);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CNT_BITS'(push_i.count) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.res1;
  end

endmodule
